FILE: hdl/ste_pkg.sv
// Shared types, constants and helpers for the system-register trap emulator.
// Used by ste_ctrl, ste_datapath and the top level; depends on nothing else.
package ste_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int KEY_W             = 16;
  localparam int VALUE_W           = 64;
  localparam int CLASS_W           = 6;
  localparam int INSTR_W           = 32;
  localparam int REG_W             = 5;

  localparam logic [INSTR_W-1:0] SYS_MASK     = 32'hFFC0_0000;
  localparam logic [INSTR_W-1:0] SYS_MATCH    = 32'hD500_0000;
  localparam logic [INSTR_W-1:0] MOVE_MASK    = 32'hFFF0_0000;
  localparam logic [INSTR_W-1:0] MOVE_WRITE   = 32'hD510_0000;
  localparam logic [INSTR_W-1:0] MOVE_READ    = 32'hD530_0000;
  localparam logic [REG_W-1:0]   ZERO_REG     = 5'h1F;
  localparam logic [CLASS_W-1:0] CLASS_HANDLE = 6'h00;
  localparam logic [VALUE_W-1:0] INSTR_BYTES  = 64'd4;

  typedef struct packed {
    logic [CLASS_W-1:0] exception_class;
    logic [INSTR_W-1:0] instruction;
    logic [VALUE_W-1:0] source_value;
    logic [VALUE_W-1:0] return_address;
  } item_t;

  typedef struct packed {
    logic               handled;
    logic               writes_register;
    logic [REG_W-1:0]   dest_register;
    logic [VALUE_W-1:0] read_value;
    logic               table_full;
    logic [VALUE_W-1:0] resume_address;
  } result_t;

  typedef enum logic [1:0] {
    OP_REFUSE,
    OP_OTHER,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CAPTURE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic hit_write;
    logic capture;
    logic append;
    logic set_full;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic match;
    logic scan_done;
    logic room;
    logic out_free;
  } status_t;

  function automatic logic [KEY_W-1:0] pack_key(input logic [INSTR_W-1:0] word);
    return {word[20:19], word[18:16], word[15:12], word[11:8], word[7:5]};
  endfunction

endpackage

FILE: hdl/ste_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ste_ram #(
  parameter int  WIDTH  = 16,
  parameter int  DEPTH  = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ste_ctrl.sv
// Controller state machine: sequences decode, table scan, update and result load.
// Depends on ste_pkg.
module ste_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ste_pkg::status_t  status,
  output ste_pkg::cmd_t     cmd
);
  import ste_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (status.op == OP_WRITE || status.op == OP_READ) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (status.match && status.op == OP_READ) begin
          state_next = S_CAPTURE;
        end else if (status.match || status.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_CAPTURE: state_next = S_FINISH;
      S_FINISH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: ;
      S_SCAN: begin
        if (status.match) begin
          cmd.hit_write = (status.op == OP_WRITE);
        end else if (status.scan_done) begin
          if (status.op == OP_WRITE) begin
            cmd.append   = status.room;
            cmd.set_full = !status.room;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CAPTURE: cmd.capture = 1'b1;
      S_FINISH:  cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/ste_datapath.sv
// Datapath: item register, key/value table RAMs, scan counter and result register.
// Depends on ste_pkg and ste_ram.
module ste_datapath #(
  parameter int TABLE_ENTRIES = ste_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ste_pkg::item_t    in_word,
  output ste_pkg::result_t  out_word,
  output logic              out_valid,
  input  logic              out_ready,
  input  ste_pkg::cmd_t     cmd,
  output ste_pkg::status_t  status
);
  import ste_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(TABLE_ENTRIES);

  item_t              item;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   slot;
  logic               pend;
  logic [VALUE_W-1:0] rdval;
  logic               full;
  op_t                op;
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] value_rdata;
  logic [VALUE_W-1:0] wval;
  logic [REG_W-1:0]   rt;
  logic               room;
  logic               key_we;
  logic               value_we;
  logic [IDX_W-1:0]   value_waddr;
  result_t            result;

  assign rt   = item.instruction[REG_W-1:0];
  assign key  = pack_key(item.instruction);
  assign wval = (rt == ZERO_REG) ? '0 : item.source_value;
  assign room = (count < LIMIT);

  always_comb begin
    if (item.exception_class != CLASS_HANDLE ||
        (item.instruction & SYS_MASK) != SYS_MATCH) begin
      op = OP_REFUSE;
    end else if ((item.instruction & MOVE_MASK) == MOVE_WRITE) begin
      op = OP_WRITE;
    end else if ((item.instruction & MOVE_MASK) == MOVE_READ) begin
      op = OP_READ;
    end else begin
      op = OP_OTHER;
    end
  end

  assign key_we      = cmd.append && room;
  assign value_we    = cmd.hit_write || key_we;
  assign value_waddr = cmd.hit_write ? slot : count[IDX_W-1:0];

  ste_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (key),
    .raddr (idx[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  ste_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (value_waddr),
    .wdata (wval),
    .raddr (slot),
    .rdata (value_rdata)
  );

  assign status.op        = op;
  assign status.match     = pend && (key_rdata == key);
  assign status.scan_done = (idx == count);
  assign status.room      = room;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (key_we) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= (idx < count);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_word;
      idx   <= '0;
      rdval <= '0;
      full  <= 1'b0;
    end else begin
      if (cmd.scan_step && idx < count) begin
        slot <= idx[IDX_W-1:0];
        idx  <= idx + CNT_W'(1);
      end
      if (cmd.capture) begin
        rdval <= value_rdata;
      end
      if (cmd.set_full) begin
        full <= 1'b1;
      end
    end
  end

  always_comb begin
    result = '0;
    if (op != OP_REFUSE) begin
      result.handled        = 1'b1;
      result.table_full     = full;
      result.resume_address = item.return_address + INSTR_BYTES;
      if (op == OP_READ && rt != ZERO_REG) begin
        result.writes_register = 1'b1;
        result.dest_register   = rt;
        result.read_value      = rdval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= result;
    end
  end

endmodule

FILE: hdl/sysreg_trap_emulator_unit.sv
// Top level of the system-register trap emulator: controller plus datapath.
// Depends on ste_pkg, ste_ctrl, ste_datapath and ste_ram.
//
// Emulates trapped system-register moves against an associative table of
// TABLE_ENTRIES key/value pairs held in two RAMs. One word is processed at a
// time. A refused or non-move word passes from DECODE straight to FINISH. A
// move scans the key RAM one entry per cycle over the N stored entries (up
// to TABLE_ENTRIES); a miss goes on to FINISH once all N are examined. A hit
// stops the scan at the matching entry: a write goes on to FINISH, while a
// read first passes through CAPTURE for the value RAM read.
// The result sits in an output register, so the next word is accepted while a
// finished result waits; only a second finished result stalls until the first
// is taken. The table needs no clearing after reset: only entries below the
// fill count are ever examined.
module sysreg_trap_emulator_unit #(
  parameter int TABLE_ENTRIES = ste_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ste_pkg::item_t    in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output ste_pkg::result_t  out_word
);
  import ste_pkg::*;

  cmd_t    cmd;
  status_t status;

  ste_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ste_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
